// ===== rtl/iba_pkg.sv =====
// shared types and constants for the inode bitmap allocator
// no dependencies

package iba_pkg;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_BITS,
        ST_DATA,
        ST_OUT
    } state_t;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_TEST  = 2'd2;

    localparam int WORD_W      = 64;
    localparam int WORD_LIMIT  = 128;
    localparam int CHUNK_W     = 16;
    localparam int CHUNK_IDX_W = 4;
    localparam int NUM_W       = 13;
    localparam int WORD_IDX_W  = 7;
    localparam int BIT_IDX_W   = 6;
    localparam int CFG_W       = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    localparam int OUT_STATUS_BIT = 13;
    localparam int OUT_INUSE_BIT  = 14;

endpackage

// ===== rtl/iba_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module iba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/iba_ffz.sv =====
// find first zero over one 16-bit chunk, the shared search unit
// depends on iba_pkg

module iba_ffz import iba_pkg::*;
(
    input  logic [CHUNK_W-1:0]     vec,
    output logic                   found,
    output logic [CHUNK_IDX_W-1:0] idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--)
        begin
            if (!vec[j])
            begin
                found = 1'b1;
                idx   = CHUNK_IDX_W'(j);
            end
        end
    end

endmodule

// ===== rtl/inode_bitmap_allocator.sv =====
// top level of the inode bitmap allocator: sequencer, full-word summary and bitmap ram
// depends on iba_pkg, iba_ram, iba_ffz

// Allocate, free or test inode numbers in a bitmap of MAP_WORDS 64-bit words held in
// one ram. After reset a clearing pass writes every word to zero with s_axis_tready
// low; cfg writes are taken meanwhile. One request is taken at a time. Free and test
// read the word, then update it or test the bit, then give the result. An unknown
// mode or a number beyond the bitmap goes straight to the result. Allocate scans a
// per-word full flag vector 16 words a cycle through the shared first-zero unit, reads
// the chosen word, then scans it 16 bits a cycle with the same unit.
// Exhaustion is flagged in status with granted number zero.

module inode_bitmap_allocator import iba_pkg::*;
#(
    parameter int MAP_WORDS = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // inode_number[12:0], zero pad [15:13]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // granted_number[12:0], status[13], in_use[14], zero pad [15]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_W = (MAP_WORDS < WORD_LIMIT) ? MAP_WORDS : WORD_LIMIT;
    localparam int SW    = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam int NCH   = (SUM_W + CHUNK_W - 1) / CHUNK_W;
    localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PAD_W = NCH * CHUNK_W;
    localparam int BCH   = WORD_W / CHUNK_W;
    localparam int BCW   = $clog2(BCH);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]      active_reg, active_next;
    logic [1:0]            mode_reg, mode_next;
    logic [WORD_IDX_W-1:0] word_sel_reg, word_sel_next;
    logic [BIT_IDX_W-1:0]  bit_reg, bit_next;
    logic [CW-1:0]         chunk_reg, chunk_next;
    logic [BCW-1:0]        bchunk_reg, bchunk_next;
    logic [SUM_W-1:0]      full_reg, full_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [NUM_W-1:0]      res_granted_reg, res_granted_next;
    logic                  res_status_reg, res_status_next;
    logic                  res_inuse_reg, res_inuse_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  in_accept;
    logic [WORD_IDX_W-1:0] in_word;
    logic                  in_range;
    logic [NUM_W-1:0]      word_ext;
    logic [AW-1:0]         word_addr;
    logic [SW-1:0]         sum_idx;
    logic [CFG_W-1:0]      lim;
    logic [PAD_W-1:0]      full_pad;
    logic [CHUNK_W-1:0]    scan_chunk;
    logic [CHUNK_W-1:0]    cand;
    logic [CHUNK_W-1:0]    ffz_vec;
    logic                  ffz_found;
    logic [CHUNK_IDX_W-1:0] ffz_idx;
    logic [BIT_IDX_W-1:0]  bit_pos;
    logic [WORD_W-1:0]     set_word;
    logic                  out_free;
    logic                  last_chunk;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_word    = s_axis_tdata[NUM_W-1:BIT_IDX_W];
    assign in_range   = {{(NUM_W-WORD_IDX_W){1'b0}}, in_word} < NUM_W'(MAP_WORDS);
    assign word_ext   = {{(NUM_W-WORD_IDX_W){1'b0}}, word_sel_reg};
    assign word_addr  = word_ext[AW-1:0];
    assign sum_idx    = word_ext[SW-1:0];
    assign lim        = (active_reg > CFG_W'(SUM_W)) ? CFG_W'(SUM_W) : active_reg;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign last_chunk = chunk_reg == CW'(NCH - 1);
    assign bit_pos    = {bchunk_reg, ffz_idx};
    assign set_word   = ram_rdata | (WORD_W'(1) << bit_pos);

    // full flags padded with ones up to whole chunks, words past the limit masked
    always_comb
    begin
        full_pad             = '1;
        full_pad[SUM_W-1:0]  = full_reg;
        scan_chunk           = full_pad[chunk_reg*CHUNK_W +: CHUNK_W];
        for (int j = 0; j < CHUNK_W; j++)
        begin
            cand[j] = scan_chunk[j]
                      | ({1'b0, 3'(chunk_reg), CHUNK_IDX_W'(j)} >= lim);
        end
    end

    assign ffz_vec = (state_reg == ST_SCAN) ? cand
                                            : ram_rdata[bchunk_reg*CHUNK_W +: CHUNK_W];

    iba_ffz u_ffz
    (
        .vec   (ffz_vec),
        .found (ffz_found),
        .idx   (ffz_idx)
    );

    iba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (word_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser) inside
                        MODE_ALLOC:           state_next = ST_SCAN;
                        MODE_FREE, MODE_TEST: state_next = in_range ? ST_READ : ST_OUT;
                        default:              state_next = ST_OUT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (ffz_found)
                begin
                    state_next = ST_READ;
                end
                else if (last_chunk)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_READ:
            begin
                state_next = (mode_reg == MODE_ALLOC) ? ST_BITS : ST_DATA;
            end
            ST_BITS:
            begin
                if (ffz_found || bchunk_reg == BCW'(BCH - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DATA:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        active_next      = cfg_we ? cfg_wdata : active_reg;
        mode_next        = mode_reg;
        word_sel_next    = word_sel_reg;
        bit_next         = bit_reg;
        chunk_next       = chunk_reg;
        bchunk_next      = bchunk_reg;
        full_next        = full_reg;
        clr_cnt_next     = clr_cnt_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        res_inuse_next   = res_inuse_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        ram_we           = 1'b0;
        ram_waddr        = word_addr;
        ram_wdata        = set_word;
        ram_re           = 1'b0;
        s_axis_tready    = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    mode_next        = s_axis_tuser;
                    word_sel_next    = in_word;
                    bit_next         = s_axis_tdata[BIT_IDX_W-1:0];
                    chunk_next       = '0;
                    bchunk_next      = '0;
                    res_granted_next = '0;
                    res_status_next  = 1'b0;
                    res_inuse_next   = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (ffz_found)
                begin
                    word_sel_next = {3'(chunk_reg), ffz_idx};
                end
                else if (last_chunk)
                begin
                    res_status_next = 1'b1;
                end
                else
                begin
                    chunk_next = chunk_reg + CW'(1);
                end
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_BITS:
            begin
                if (ffz_found)
                begin
                    ram_we           = 1'b1;
                    res_granted_next = {word_sel_reg, bit_pos};
                    if (&set_word)
                    begin
                        full_next[sum_idx] = 1'b1;
                    end
                end
                else
                begin
                    bchunk_next = bchunk_reg + BCW'(1);
                end
            end
            ST_DATA:
            begin
                if (mode_reg == MODE_FREE)
                begin
                    ram_we             = 1'b1;
                    ram_wdata          = ram_rdata & ~(WORD_W'(1) << bit_reg);
                    full_next[sum_idx] = 1'b0;
                end
                else
                begin
                    res_inuse_next = ram_rdata[bit_reg];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_inuse_reg, res_status_reg, res_granted_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            active_reg    <= CFG_W'(WORD_LIMIT);
            full_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            full_reg      <= full_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        word_sel_reg    <= word_sel_next;
        bit_reg         <= bit_next;
        chunk_reg       <= chunk_next;
        bchunk_reg      <= bchunk_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        res_inuse_reg   <= res_inuse_next;
        out_data_reg    <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/iba_checker.sv =====
// port-level assertions for the inode bitmap allocator, bound to the top level
// depends on iba_pkg and inode_bitmap_allocator

module iba_checker import iba_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // exhaustion carries no number and no in-use flag
    a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_STATUS_BIT]
        |-> m_axis_tdata[NUM_W-1:0] == '0 && !m_axis_tdata[OUT_INUSE_BIT])
        else $error("exhaustion result with number or in-use set");

    // test answer carries no number and no exhaustion
    a_test_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_INUSE_BIT]
        |-> m_axis_tdata[NUM_W-1:0] == '0 && !m_axis_tdata[OUT_STATUS_BIT])
        else $error("in-use result with number or status set");

    // padding bit stays clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[OUT_TDATA_W-1])
        else $error("result padding bit set");

endmodule

bind inode_bitmap_allocator iba_checker u_iba_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
